@@ rtl/bmdc_pkg.sv @@
// Shared types and fixed constants for the bitmask dictionary decompressor.
// No dependencies.
`default_nettype none

package bmdc_pkg;

    localparam int TYPE_BITS   = 3;
    localparam int LOC_BITS    = 5;
    localparam int MASK_BITS   = 4;
    localparam int COUNT_BITS  = 3;
    localparam int RECORD_BITS = 35;
    localparam int CNT_BITS    = 6;

    // flip patterns, aligned to the top of a nibble
    localparam logic [MASK_BITS-1:0] NIB_ONE  = 4'b1000;
    localparam logic [MASK_BITS-1:0] NIB_TWO  = 4'b1100;
    localparam logic [MASK_BITS-1:0] NIB_FOUR = 4'b1111;
    localparam logic [MASK_BITS-1:0] NIB_NONE = 4'b0000;

    localparam logic STATUS_WORD    = 1'b0;
    localparam logic STATUS_NO_PREV = 1'b1;

    typedef enum logic [1:0] {
        OP_BIT   = 2'd0,
        OP_WRITE = 2'd1,
        OP_END   = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        REC_RAW    = 3'd0,
        REC_RUN    = 3'd1,
        REC_MASK   = 3'd2,
        REC_ONE    = 3'd3,
        REC_TWO    = 3'd4,
        REC_FOUR   = 3'd5,
        REC_PAIR   = 3'd6,
        REC_DIRECT = 3'd7
    } rec_type_t;

    typedef enum logic [1:0] {
        JOB_RAW  = 2'd0,
        JOB_DICT = 2'd1,
        JOB_RUN  = 2'd2,
        JOB_ERR  = 2'd3
    } job_kind_t;

endpackage

`default_nettype wire

@@ rtl/bitmask_code_decompressor.sv @@
// Bitmask dictionary decompressor top level: record parser, job stage, output register.
// Depends on bmdc_pkg and bmdc_dict.
//
//   channel  | valid         | stall         | payload
//   ---------+---------------+---------------+-------------------------------------
//   item     | item_valid    | item_stall    | op, stream_bit, entry_index, entry_word
//   result   | result_valid  | result_stall  | word_out, status, run_last
//
// One item per cycle while item_stall is low. A completed record becomes a job;
// its dictionary read is registered with the job, and the word enters the output
// register when it has room. A run record holds the job stage for count+1 output
// beats; the item side stalls only while the job stage is full and cannot drain.
// Reset clears the parser, the job and output stages and all dictionary valid bits.
`default_nettype none

module bitmask_code_decompressor
    import bmdc_pkg::*;
#(
    parameter int INDEX_BITS = 4,
    parameter int WORD_BITS  = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire logic [1:0]  op,
    input  wire logic        stream_bit,
    input  wire logic [3:0]  entry_index,
    input  wire logic [31:0] entry_word,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [31:0]      word_out,
    output logic             status,
    output logic             run_last
);

    localparam logic [CNT_BITS-1:0] LEN_RAW  = CNT_BITS'(TYPE_BITS + WORD_BITS);
    localparam logic [CNT_BITS-1:0] LEN_RUN  = CNT_BITS'(TYPE_BITS + COUNT_BITS);
    localparam logic [CNT_BITS-1:0] LEN_MASK =
        CNT_BITS'(TYPE_BITS + LOC_BITS + MASK_BITS + INDEX_BITS);
    localparam logic [CNT_BITS-1:0] LEN_FLIP = CNT_BITS'(TYPE_BITS + LOC_BITS + INDEX_BITS);
    localparam logic [CNT_BITS-1:0] LEN_PAIR =
        CNT_BITS'(TYPE_BITS + 2 * LOC_BITS + INDEX_BITS);
    localparam logic [CNT_BITS-1:0] LEN_DIRECT = CNT_BITS'(TYPE_BITS + INDEX_BITS);
    localparam logic [CNT_BITS-1:0] CNT_TYPE   = CNT_BITS'(TYPE_BITS);

    // parser state
    logic [RECORD_BITS-1:0] rec_reg;
    logic [CNT_BITS-1:0]    cnt_reg;
    rec_type_t              type_reg;
    logic                   halted_reg;
    logic                   have_prev_reg;
    logic [WORD_BITS-1:0]   prev_reg;

    // job stage
    logic                   job_valid_reg;
    job_kind_t              kind_reg, kind_next;
    logic [MASK_BITS-1:0]   nib_reg, nib_next;
    logic [LOC_BITS-1:0]    loc_reg, loc_next;
    logic [LOC_BITS-1:0]    loc2_reg, loc2_next;
    logic                   pair_reg, pair_next;
    logic [WORD_BITS-1:0]   raw_reg;
    logic [COUNT_BITS-1:0]  rep_reg;

    // output stage
    logic                   out_valid_reg;
    logic [WORD_BITS-1:0]   out_word_reg;
    logic                   out_status_reg;
    logic                   out_last_reg;

    logic                   item_fire;
    logic                   bit_take;
    logic                   end_take;
    logic [RECORD_BITS-1:0] rec_shift;
    logic [CNT_BITS-1:0]    cnt_inc;
    rec_type_t              cur_type;
    logic [CNT_BITS-1:0]    need;
    logic                   err_hit;
    logic                   done;
    logic                   job_load;
    logic                   out_space;
    logic                   out_load;
    logic                   job_go;
    logic                   word_job;
    logic [WORD_BITS-1:0]   dict_word;
    logic [WORD_BITS-1:0]   flip_top;
    logic [WORD_BITS-1:0]   flip_pair;
    logic [WORD_BITS-1:0]   job_word;

    assign item_fire = item_valid && !item_stall;
    assign bit_take  = item_fire && (op == OP_BIT) && !halted_reg;
    assign end_take  = item_fire && (op == OP_END);

    assign rec_shift = {rec_reg[RECORD_BITS-2:0], stream_bit};
    assign cnt_inc   = cnt_reg + CNT_BITS'(1);
    assign cur_type  = (cnt_inc == CNT_TYPE) ? rec_type_t'(rec_shift[TYPE_BITS-1:0])
                                             : type_reg;

    always_comb
    begin
        unique case (cur_type)
            REC_RAW:                    need = LEN_RAW;
            REC_RUN:                    need = LEN_RUN;
            REC_MASK:                   need = LEN_MASK;
            REC_ONE, REC_TWO, REC_FOUR: need = LEN_FLIP;
            REC_PAIR:                   need = LEN_PAIR;
            default:                    need = LEN_DIRECT;
        endcase
    end

    assign err_hit  = bit_take && (cnt_inc == CNT_TYPE) && (cur_type == REC_RUN)
                      && !have_prev_reg;
    assign done     = bit_take && !err_hit && (cnt_inc == need);
    assign job_load = err_hit || done;

    // job decode; every field sits right-aligned once the record is complete
    always_comb
    begin
        kind_next = JOB_DICT;
        nib_next  = NIB_NONE;
        loc_next  = rec_shift[INDEX_BITS+LOC_BITS-1:INDEX_BITS];
        loc2_next = '0;
        pair_next = 1'b0;
        if (err_hit)
        begin
            kind_next = JOB_ERR;
        end
        else
        begin
            unique case (cur_type)
                REC_RAW:  kind_next = JOB_RAW;
                REC_RUN:  kind_next = JOB_RUN;
                REC_MASK:
                begin
                    nib_next = rec_shift[INDEX_BITS+MASK_BITS-1:INDEX_BITS];
                    loc_next = rec_shift[INDEX_BITS+MASK_BITS+LOC_BITS-1:
                                         INDEX_BITS+MASK_BITS];
                end
                REC_ONE:  nib_next = NIB_ONE;
                REC_TWO:  nib_next = NIB_TWO;
                REC_FOUR: nib_next = NIB_FOUR;
                REC_PAIR:
                begin
                    nib_next  = NIB_ONE;
                    loc_next  = rec_shift[INDEX_BITS+2*LOC_BITS-1:INDEX_BITS+LOC_BITS];
                    loc2_next = rec_shift[INDEX_BITS+LOC_BITS-1:INDEX_BITS];
                    pair_next = 1'b1;
                end
                default:  nib_next = NIB_NONE;
            endcase
        end
    end

    bmdc_dict #(
        .INDEX_BITS (INDEX_BITS),
        .WORD_BITS  (WORD_BITS)
    ) u_dict (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (item_fire && (op == OP_WRITE)),
        .wr_addr (INDEX_BITS'(entry_index)),
        .wr_data (WORD_BITS'(entry_word)),
        .rd_en   (done && (cur_type != REC_RAW) && (cur_type != REC_RUN)),
        .rd_addr (rec_shift[INDEX_BITS-1:0]),
        .rd_data (dict_word)
    );

    assign flip_top  = {nib_reg, {(WORD_BITS-MASK_BITS){1'b0}}} >> loc_reg;
    assign flip_pair = pair_reg ? ({1'b1, {(WORD_BITS-1){1'b0}}} >> loc2_reg) : '0;

    always_comb
    begin
        unique case (kind_reg)
            JOB_RAW:  job_word = raw_reg;
            JOB_DICT: job_word = dict_word ^ flip_top ^ flip_pair;
            JOB_RUN:  job_word = prev_reg;
            default:  job_word = '0;
        endcase
    end

    assign word_job   = (kind_reg == JOB_RAW) || (kind_reg == JOB_DICT);
    assign out_space  = !out_valid_reg || !result_stall;
    assign out_load   = job_valid_reg && out_space;
    assign job_go     = out_load && ((kind_reg != JOB_RUN) || (rep_reg == '0));
    assign item_stall = job_valid_reg && !job_go;

    // parser
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_reg       <= '0;
            cnt_reg       <= '0;
            type_reg      <= REC_RAW;
            halted_reg    <= 1'b0;
            have_prev_reg <= 1'b0;
        end
        else if (end_take)
        begin
            rec_reg       <= '0;
            cnt_reg       <= '0;
            halted_reg    <= 1'b0;
            have_prev_reg <= 1'b0;
        end
        else if (bit_take)
        begin
            if (job_load)
            begin
                rec_reg <= '0;
                cnt_reg <= '0;
            end
            else
            begin
                rec_reg <= rec_shift;
                cnt_reg <= cnt_inc;
            end
            if (cnt_inc == CNT_TYPE)
            begin
                type_reg <= cur_type;
            end
            if (err_hit)
            begin
                halted_reg <= 1'b1;
            end
            if (done && (cur_type != REC_RUN))
            begin
                have_prev_reg <= 1'b1;
            end
        end
    end

    // last word; end of stream wins over a word leaving the job stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
        end
        else if (end_take)
        begin
            prev_reg <= '0;
        end
        else if (out_load && word_job)
        begin
            prev_reg <= job_word;
        end
    end

    // job stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            rep_reg       <= '0;
        end
        else
        begin
            if (job_load)
            begin
                job_valid_reg <= 1'b1;
                rep_reg       <= rec_shift[COUNT_BITS-1:0];
            end
            else
            begin
                if (job_go)
                begin
                    job_valid_reg <= 1'b0;
                end
                if (out_load && (kind_reg == JOB_RUN) && (rep_reg != '0))
                begin
                    rep_reg <= rep_reg - COUNT_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_load)
        begin
            kind_reg <= kind_next;
            nib_reg  <= nib_next;
            loc_reg  <= loc_next;
            loc2_reg <= loc2_next;
            pair_reg <= pair_next;
            raw_reg  <= rec_shift[WORD_BITS-1:0];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_word_reg   <= job_word;
            out_status_reg <= (kind_reg == JOB_ERR) ? STATUS_NO_PREV : STATUS_WORD;
            out_last_reg   <= (kind_reg != JOB_RUN) || (rep_reg == '0);
        end
    end

    assign result_valid = out_valid_reg;
    assign word_out     = 32'(out_word_reg);
    assign status       = out_status_reg;
    assign run_last     = out_last_reg;

endmodule

`default_nettype wire

@@ rtl/bmdc_dict.sv @@
// Dictionary store: one write port, one registered read port, per-entry valid bits.
// Entries never written since reset read as zero. Uses bmdc_pkg.
`default_nettype none

module bmdc_dict
    import bmdc_pkg::*;
#(
    parameter int INDEX_BITS = 4,
    parameter int WORD_BITS  = 32
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  wr_en,
    input  wire logic [INDEX_BITS-1:0] wr_addr,
    input  wire logic [WORD_BITS-1:0]  wr_data,
    input  wire logic                  rd_en,
    input  wire logic [INDEX_BITS-1:0] rd_addr,
    output logic      [WORD_BITS-1:0]  rd_data
);

    localparam int DEPTH = 1 << INDEX_BITS;

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [DEPTH-1:0]     valid_reg;
    logic [WORD_BITS-1:0] data_reg;
    logic                 hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                hit_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = hit_reg ? data_reg : '0;

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for bitmask_code_decompressor: queue-fed bit-serial driver,
// result monitor with an in-line decompression predictor, random idle and stall mixes.
// Depends on bmdc_pkg and the RTL of bitmask_code_decompressor.
module testbench;
    import bmdc_pkg::*;

    localparam int IDX_BITS = 4;
    localparam int WORD_W = 32;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [1:0] op;
        logic sbit;
        logic [3:0] idx;
        logic [31:0] word;
    } stream_item_t;

    typedef struct packed {
        logic [31:0] word;
        logic status;
        logic last;
    } word_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    logic [1:0] op = OP_BIT;
    logic stream_bit = 1'b0;
    logic [3:0] entry_index = '0;
    logic [31:0] entry_word = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    logic [31:0] word_out;
    logic status;
    logic run_last;

    stream_item_t stream_queue[$];
    word_result_t expected_words[$];

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    logic pressure_on = 1'b0;
    logic hold_done = 1'b0;
    int unsigned hold_count = 0;
    int unsigned cycle_count = 0;
    int unsigned items_queued = 0;
    int unsigned items_accepted = 0;
    int unsigned results_checked = 0;
    int unsigned error_beats = 0;
    int unsigned stream_ends = 0;
    int unsigned mismatches = 0;
    logic stream_has_word = 1'b0;

    // predictor state
    logic [34:0] part_bits;
    int unsigned part_len;
    logic [31:0] prev_word;
    logic has_prev;
    logic halted_m;
    logic [31:0] dict_model [16];

    bitmask_code_decompressor dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .op(op),
        .stream_bit(stream_bit),
        .entry_index(entry_index),
        .entry_word(entry_word),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .word_out(word_out),
        .status(status),
        .run_last(run_last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned record_length(rec_type_t t);
        case (t)
            REC_RAW: return TYPE_BITS + WORD_W;
            REC_RUN: return TYPE_BITS + COUNT_BITS;
            REC_MASK: return TYPE_BITS + LOC_BITS + MASK_BITS + IDX_BITS;
            REC_ONE, REC_TWO, REC_FOUR: return TYPE_BITS + LOC_BITS + IDX_BITS;
            REC_PAIR: return TYPE_BITS + 2 * LOC_BITS + IDX_BITS;
            default: return TYPE_BITS + IDX_BITS;
        endcase
    endfunction

    function automatic logic [31:0] field_at(logic [34:0] rec, int unsigned lsb,
                                             int unsigned n);
        logic [34:0] m;
        m = (35'd1 << n) - 35'd1;
        return 32'((rec >> lsb) & m);
    endfunction

    // nibble pattern placed at the MSB, shifted toward the LSB, overflow dropped
    function automatic logic [31:0] flip_at(logic [3:0] nib, int unsigned loc);
        return {nib, 28'd0} >> loc;
    endfunction

    function automatic void add_expected(logic [31:0] w, logic st, logic lst);
        word_result_t beat;
        beat.word = w;
        beat.status = st;
        beat.last = lst;
        expected_words.insert(expected_words.size(), beat);
    endfunction

    task automatic decompress_step(input logic [1:0] op_i, input logic bit_i,
                                   input logic [3:0] idx_i, input logic [31:0] word_i);
        rec_type_t rtype;
        int unsigned need;
        int unsigned left;
        int unsigned loc;
        int unsigned loc2;
        int count;
        logic [3:0] msk;
        logic [31:0] w;
        case (op_i)
            OP_WRITE: dict_model[idx_i] = word_i;
            OP_END:
            begin
                part_bits = '0;
                part_len = 0;
                halted_m = 1'b0;
                has_prev = 1'b0;
                prev_word = '0;
            end
            OP_BIT:
            begin
                if (!halted_m)
                begin
                    part_bits = {part_bits[33:0], bit_i};
                    part_len++;
                    if (part_len >= TYPE_BITS)
                    begin
                        rtype = rec_type_t'(3'(part_bits >> (part_len - TYPE_BITS)));
                        need = record_length(rtype);
                        if (part_len == TYPE_BITS && rtype == REC_RUN && !has_prev)
                        begin
                            add_expected(32'd0, STATUS_NO_PREV, 1'b1);
                            error_beats++;
                            part_bits = '0;
                            part_len = 0;
                            halted_m = 1'b1;
                        end
                        else if (part_len == need)
                        begin
                            left = need - TYPE_BITS;
                            if (rtype == REC_RUN)
                            begin
                                left -= COUNT_BITS;
                                count = int'(field_at(part_bits, left, COUNT_BITS)) + 1;
                                for (int k = 0; k < count; k++)
                                    add_expected(prev_word, STATUS_WORD, k == count - 1);
                            end
                            else
                            begin
                                if (rtype == REC_RAW)
                                begin
                                    left -= WORD_W;
                                    w = field_at(part_bits, left, WORD_W);
                                end
                                else
                                begin
                                    loc = 0;
                                    loc2 = 0;
                                    msk = NIB_NONE;
                                    if (rtype != REC_DIRECT)
                                    begin
                                        left -= LOC_BITS;
                                        loc = field_at(part_bits, left, LOC_BITS);
                                    end
                                    if (rtype == REC_MASK)
                                    begin
                                        left -= MASK_BITS;
                                        msk = 4'(field_at(part_bits, left, MASK_BITS));
                                    end
                                    if (rtype == REC_PAIR)
                                    begin
                                        left -= LOC_BITS;
                                        loc2 = field_at(part_bits, left, LOC_BITS);
                                    end
                                    left -= IDX_BITS;
                                    w = dict_model[4'(field_at(part_bits, left, IDX_BITS))];
                                    case (rtype)
                                        REC_MASK: w ^= flip_at(msk, loc);
                                        REC_ONE: w ^= flip_at(NIB_ONE, loc);
                                        REC_TWO: w ^= flip_at(NIB_TWO, loc);
                                        REC_FOUR: w ^= flip_at(NIB_FOUR, loc);
                                        REC_PAIR:
                                            w ^= flip_at(NIB_ONE, loc) ^ flip_at(NIB_ONE, loc2);
                                        default: ;
                                    endcase
                                end
                                prev_word = w;
                                has_prev = 1'b1;
                                add_expected(w, STATUS_WORD, 1'b1);
                            end
                            part_bits = '0;
                            part_len = 0;
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic queue_item(logic [1:0] op_i, logic bit_i, logic [3:0] idx_i,
                              logic [31:0] word_i);
        stream_item_t entry;
        entry = '{op_i, bit_i, idx_i, word_i};
        stream_queue.insert(stream_queue.size(), entry);
        items_queued++;
    endtask

    task automatic push_bits(logic [31:0] value, int n);
        for (int i = n - 1; i >= 0; i--)
            queue_item(OP_BIT, value[i], 4'($urandom), $urandom);
    endtask

    task automatic push_write(logic [3:0] idx, logic [31:0] word);
        queue_item(OP_WRITE, 1'($urandom), idx, word);
    endtask

    task automatic push_end();
        queue_item(OP_END, 1'($urandom), 4'($urandom), $urandom);
        stream_has_word = 1'b0;
    endtask

    task automatic push_record(rec_type_t t, logic [31:0] raw, int unsigned loc1,
                               int unsigned loc2, logic [3:0] msk, logic [3:0] idx,
                               logic [2:0] count);
        push_bits(t, TYPE_BITS);
        case (t)
            REC_RAW: push_bits(raw, WORD_W);
            REC_RUN: push_bits(count, COUNT_BITS);
            REC_DIRECT: push_bits(idx, IDX_BITS);
            default:
            begin
                push_bits(loc1, LOC_BITS);
                if (t == REC_MASK)
                    push_bits(msk, MASK_BITS);
                if (t == REC_PAIR)
                    push_bits(loc2, LOC_BITS);
                push_bits(idx, IDX_BITS);
            end
        endcase
        if (t != REC_RUN)
            stream_has_word = 1'b1;
    endtask

    function automatic logic [31:0] random_word();
        case ($urandom_range(9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_random_record();
        rec_type_t t;
        t = rec_type_t'($urandom_range(7));
        if (t == REC_RUN && !stream_has_word)
            t = REC_RAW;
        push_record(t, random_word(), $urandom_range(31), $urandom_range(31),
                    4'($urandom), 4'($urandom), 3'($urandom));
    endtask

    task automatic random_traffic(int unsigned n);
        int unsigned stop_at;
        int unsigned pick;
        stop_at = items_queued + n;
        while (items_queued < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 68)
                push_random_record();
            else if (pick < 78)
                push_write(4'($urandom), random_word());
            else if (pick < 83)
                push_end();
            else if (pick < 88)
            begin
                // run with no word before it, then bits the halted block ignores
                push_end();
                push_record(REC_RUN, 0, 0, 0, 0, 0, 3'($urandom));
                push_bits($urandom, $urandom_range(1, 6));
                if ($urandom_range(1))
                    push_write(4'($urandom), random_word());
                push_end();
            end
            else if (pick < 93)
            begin
                // partial record cut off by end of stream
                push_bits($urandom, $urandom_range(1, 12));
                push_end();
            end
            else
                queue_item(OP_UNUSED, 1'($urandom), 4'($urandom), $urandom);
        end
    endtask

    task automatic wait_accepted();
        while (items_accepted != items_queued)
            @(posedge clk);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : driver
        stream_item_t nxt;
        if (rst_n && (!item_valid || !item_stall))
        begin
            if (stream_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = stream_queue.pop_front();
                item_valid <= 1'b1;
                op <= nxt.op;
                stream_bit <= nxt.sbit;
                entry_index <= nxt.idx;
                entry_word <= nxt.word;
            end
            else
                item_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : receiver
        if (pressure_on && !hold_done)
        begin
            result_stall <= 1'b1;
            hold_count <= hold_count + 1;
            if (hold_count == HOLD_CYCLES - 1)
                hold_done <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin : monitor
        word_result_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t: result with none expected, got word_out=%h",
                             $time, word_out);
                    $display("%0t: status=%b run_last=%b", $time, status, run_last);
                    mismatches++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    check_field("word_out", want.word, word_out);
                    check_field("status", want.status, status);
                    check_field("run_last", want.last, run_last);
                    results_checked++;
                end
            end
            if (item_valid && !item_stall)
            begin
                decompress_step(op, stream_bit, entry_index, entry_word);
                items_accepted++;
                if (op == OP_END)
                    stream_ends++;
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats still expected",
                     cycle_count, expected_words.size());
            $display("bitmask_code_decompressor: mismatch");
            $finish;
        end
    end

    initial
    begin : main
        part_bits = '0;
        part_len = 0;
        prev_word = '0;
        has_prev = 1'b0;
        halted_m = 1'b0;
        for (int i = 0; i < 16; i++)
            dict_model[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: error and halt, extremes of every record type
        push_record(REC_RUN, 0, 0, 0, 0, 0, 3'd7);
        push_bits(32'b10110, 5);
        push_write(4'd0, 32'hFFFF_FFFF);
        queue_item(OP_UNUSED, 1'b1, 4'hF, 32'hFFFF_FFFF);
        push_end();
        push_record(REC_DIRECT, 0, 0, 0, 0, 4'd15, 0);
        push_write(4'd15, 32'h8000_0001);
        push_write(4'd5, 32'h1234_5678);
        push_record(REC_RAW, 32'h0000_0000, 0, 0, 0, 0, 0);
        push_record(REC_RAW, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
        push_record(REC_RUN, 0, 0, 0, 0, 0, 3'd0);
        push_record(REC_RUN, 0, 0, 0, 0, 0, 3'd7);
        push_record(REC_MASK, 0, 0, 0, 4'hF, 4'd0, 0);
        push_record(REC_MASK, 0, 31, 0, 4'hF, 4'd15, 0);
        push_record(REC_MASK, 0, 13, 0, 4'h0, 4'd5, 0);
        push_record(REC_ONE, 0, 0, 0, 0, 4'd15, 0);
        push_record(REC_ONE, 0, 31, 0, 0, 4'd0, 0);
        push_record(REC_TWO, 0, 31, 0, 0, 4'd5, 0);
        push_record(REC_FOUR, 0, 30, 0, 0, 4'd15, 0);
        push_record(REC_FOUR, 0, 0, 0, 0, 4'd0, 0);
        push_record(REC_PAIR, 0, 7, 7, 0, 4'd5, 0);
        push_record(REC_PAIR, 0, 0, 31, 0, 4'd15, 0);
        push_record(REC_DIRECT, 0, 0, 0, 0, 4'd0, 0);
        push_bits(32'b010110, 6);
        push_end();
        push_record(REC_RUN, 0, 0, 0, 0, 0, 3'd2);
        push_end();

        random_traffic(20);
        wait_accepted();

        send_idle_pct <= 87;
        random_traffic(20);
        wait_accepted();

        send_idle_pct <= 0;
        stall_pct <= 87;
        random_traffic(20);
        wait_accepted();

        send_idle_pct <= 22;
        stall_pct <= 22;
        random_traffic(20);
        wait_accepted();

        // long output hold while bursts of runs keep arriving
        send_idle_pct <= 0;
        stall_pct <= 0;
        pressure_on <= 1'b1;
        push_record(REC_RAW, random_word(), 0, 0, 0, 0, 0);
        for (int i = 0; i < 4; i++)
        begin
            push_record(REC_RUN, 0, 0, 0, 0, 0, 3'd7);
            push_record(REC_DIRECT, 0, 0, 0, 0, 4'($urandom), 0);
        end
        while (!hold_done)
            @(posedge clk);
        wait_accepted();
        while (expected_words.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d accepted items across four idle mixes and a %0d-cycle output hold",
                 items_accepted, HOLD_CYCLES);
        $display("checked %0d result beats, %0d of them no-previous errors, %0d stream ends",
                 results_checked, error_beats, stream_ends);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("bitmask_code_decompressor: match");
        else
            $display("bitmask_code_decompressor: mismatch");
        $finish;
    end
endmodule

@@ bitmask_code_decompressor.f @@
rtl/bmdc_pkg.sv
rtl/bmdc_dict.sv
rtl/bitmask_code_decompressor.sv
tb/testbench.sv
